// ===== rtl/core/nearest_segment_projection_search_top_defines.svh =====
// Assertion macros for the RTL, used by nsps_back
`ifndef NEAREST_SEGMENT_PROJECTION_SEARCH_TOP_DEFINES_SVH
`define NEAREST_SEGMENT_PROJECTION_SEARCH_TOP_DEFINES_SVH
`ifndef SYNTH
`define NSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/nsps_pkg.sv =====
`default_nettype none
package nsps_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned IndexWidth = 16;
   localparam int unsigned ParamWidth = 16;
   localparam int unsigned DotWidth   = 72;
   localparam int unsigned SqWidth    = 128;
   localparam int unsigned QueueDepthDefault = 2;
   localparam logic [31:0] DistReset = 32'd65536000;

   localparam logic [1:0] RegQueryX = 2'd0;
   localparam logic [1:0] RegQueryY = 2'd1;
   localparam logic [1:0] RegQueryZ = 2'd2;
   localparam logic [1:0] RegMaxDist = 2'd3;

   typedef struct packed {
      logic signed [32:0] s0;
      logic signed [32:0] s1;
      logic signed [32:0] s2;
      logic signed [33:0] v10;
      logic signed [33:0] v11;
      logic signed [33:0] v12;
      logic [DotWidth-1:0] a;
      logic [DotWidth-1:0] b;
      logic                qual;
      logic [IndexWidth-1:0] index;
      logic                last;
   } work_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_DIV, BK_FOOT, BK_SQ, BK_SQRT, BK_UPD, BK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_D0, FR_D1, FR_D2, FR_PUSH
   } front_state_type;
endpackage
`default_nettype wire

// ===== rtl/core/nsps_front.sv =====
`default_nettype none
module nsps_front import nsps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_push,
   output logic in_full,
   input  wire logic [31:0] sx, sy, sz, ex, ey, ez,
   input  wire logic [IndexWidth-1:0] idx,
   input  wire logic last,
   input  wire logic [31:0] qx, qy, qz,
   output logic     w_valid,
   input  wire logic w_ready,
   output work_type w_data
);
   front_state_type st_ff, st_in;
   work_type wk_ff, wk_in;
   logic signed [33:0] v2_ff [3];
   logic signed [33:0] v2_in [3];
   logic signed [33:0] m1, m2, m3;
   logic signed [67:0] pa, pb;

   always_ff @(posedge clock) begin
      if (reset) st_ff <= FR_IDLE;
      else st_ff <= st_in;
      wk_ff <= wk_in;
      v2_ff <= v2_in;
   end

   // one component of each dot product per cycle
   always_comb begin
      m1 = wk_ff.v10; m2 = v2_ff[0];
      case (st_ff)
         FR_D1:   begin m1 = wk_ff.v11; m2 = v2_ff[1]; end
         FR_D2:   begin m1 = wk_ff.v12; m2 = v2_ff[2]; end
         default: begin m1 = wk_ff.v10; m2 = v2_ff[0]; end
      endcase
      m3 = m1;
      pa = m1 * m2;
      pb = m1 * m3;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         FR_IDLE: if (in_push) st_in = FR_D0;
         FR_D0:   st_in = FR_D1;
         FR_D1:   st_in = FR_D2;
         FR_D2:   st_in = FR_PUSH;
         FR_PUSH: if (w_ready) st_in = FR_IDLE;
         default: st_in = FR_IDLE;
      endcase
   end

   always_comb begin
      wk_in = wk_ff;
      v2_in = v2_ff;
      case (st_ff)
         FR_IDLE: begin
            wk_in.s0 = {sx[31], sx}; wk_in.s1 = {sy[31], sy}; wk_in.s2 = {sz[31], sz};
            wk_in.v10 = 34'(signed'(ex)) - 34'(signed'(sx));
            wk_in.v11 = 34'(signed'(ey)) - 34'(signed'(sy));
            wk_in.v12 = 34'(signed'(ez)) - 34'(signed'(sz));
            v2_in[0] = 34'(signed'(qx)) - 34'(signed'(sx));
            v2_in[1] = 34'(signed'(qy)) - 34'(signed'(sy));
            v2_in[2] = 34'(signed'(qz)) - 34'(signed'(sz));
            wk_in.a = '0; wk_in.b = '0;
            wk_in.index = idx; wk_in.last = last; wk_in.qual = 1'b0;
         end
         FR_D0, FR_D1, FR_D2: begin
            wk_in.a = wk_ff.a + DotWidth'(pa);
            wk_in.b = wk_ff.b + DotWidth'(pb);
            if (st_ff == FR_D2) begin
               wk_in.qual = !wk_in.a[DotWidth-1] && (wk_in.a != '0)
                  && ($signed(wk_in.a) < $signed(wk_in.b));
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      in_full = (st_ff != FR_IDLE);
      w_valid = (st_ff == FR_PUSH);
      w_data  = wk_ff;
   end
endmodule
`default_nettype wire

// ===== rtl/core/nsps_queue.sv =====
`default_nettype none
module nsps_queue import nsps_pkg::*; #(
   parameter int unsigned Depth = QueueDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic     wr_valid,
   output logic     wr_ready,
   input  wire work_type wr_data,
   output logic     rd_valid,
   input  wire logic rd_ready,
   output work_type rd_data
);
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
   work_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = (cnt_ff != (AW+1)'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// ===== rtl/core/nsps_back.sv =====
`default_nettype none
`include "nearest_segment_projection_search_top_defines.svh"
module nsps_back import nsps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic     w_valid,
   output logic     w_ready,
   input  wire work_type w_data,
   input  wire logic [31:0] qx, qy, qz,
   input  wire logic [31:0] max_dist,
   input  wire logic        max_wr,
   output logic rsp_empty,
   input  wire logic rsp_pop,
   output logic rsp_found,
   output logic [IndexWidth-1:0] rsp_best_index,
   output logic [ParamWidth-1:0] rsp_best_param,
   output logic [31:0] rsp_best_distance
);
   back_state_type st_ff, st_in;
   work_type wk_ff;
   logic [DotWidth:0] rem_ff;
   logic [ParamWidth-1:0] par_ff;
   logic [4:0] cnt_ff;
   logic signed [33:0] diff_ff [3];
   logic [SqWidth-1:0] d2_ff;
   logic [63:0] x_ff, r_ff, bit_ff;
   logic [31:0] dist_ff;
   logic [31:0] bd_ff;
   logic [IndexWidth-1:0] bi_ff;
   logic [ParamWidth-1:0] bp_ff;
   logic bf_ff;
   logic out_v_ff, out_f_ff;
   logic [IndexWidth-1:0] out_i_ff;
   logic [ParamWidth-1:0] out_p_ff;
   logic [31:0] out_d_ff;

   logic [DotWidth:0] rsh;
   logic signed [50:0] prod;
   logic signed [34:0] footd;
   logic signed [33:0] qsel, ssel_v1;
   logic signed [32:0] ssel;
   logic signed [34:0] foot;
   logic [33:0] dmag;
   logic [67:0] dsq;
   logic [1:0] ci;
   logic [63:0] rb;
   logic emit_go;

   assign ci = cnt_ff[1:0];

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: if (w_valid) st_in = w_data.qual ? BK_DIV : BK_UPD;
         BK_DIV:  if (cnt_ff == 5'd15) st_in = BK_FOOT;
         BK_FOOT: if (ci == 2'd2) st_in = BK_SQ;
         BK_SQ:   if (ci == 2'd2) st_in = BK_SQRT;
         BK_SQRT: if (cnt_ff == 5'd31) st_in = BK_UPD;
         BK_UPD:  st_in = wk_ff.last ? BK_EMIT : BK_IDLE;
         BK_EMIT: if (emit_go) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      w_ready = (st_ff == BK_IDLE);
      // a run end waits only while the previous result is still held
      emit_go = (st_ff == BK_EMIT) && (!out_v_ff || rsp_pop);
      rsp_empty = !out_v_ff;
      rsp_found = out_f_ff;
      rsp_best_index = out_i_ff;
      rsp_best_param = out_p_ff;
      rsp_best_distance = out_d_ff;
   end

   always_comb begin
      rsh = {rem_ff[DotWidth-1:0], 1'b0};
      case (ci)
         2'd1:    begin ssel = wk_ff.s1; ssel_v1 = wk_ff.v11; qsel = 34'(signed'(qy)); end
         2'd2:    begin ssel = wk_ff.s2; ssel_v1 = wk_ff.v12; qsel = 34'(signed'(qz)); end
         default: begin ssel = wk_ff.s0; ssel_v1 = wk_ff.v10; qsel = 34'(signed'(qx)); end
      endcase
      prod  = $signed({1'b0, par_ff}) * ssel_v1;
      footd = 35'(prod >>> 16);
      foot  = 35'(ssel) + footd;
      dmag  = diff_ff[ci][33] ? 34'(-diff_ff[ci]) : 34'(diff_ff[ci]);
      dsq   = dmag * dmag;
      rb    = r_ff + bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         out_v_ff <= 1'b0;
         bf_ff <= 1'b0; bd_ff <= DistReset; bi_ff <= '0; bp_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (emit_go) out_v_ff <= 1'b1;
         else if (out_v_ff && rsp_pop) out_v_ff <= 1'b0;
         case (st_ff)
            BK_UPD: if (wk_ff.qual && dist_ff < bd_ff) begin
               bd_ff <= dist_ff; bi_ff <= wk_ff.index; bp_ff <= par_ff; bf_ff <= 1'b1;
            end
            BK_EMIT: if (emit_go) begin
               bf_ff <= 1'b0; bi_ff <= '0; bp_ff <= '0; bd_ff <= max_dist;
            end
            default: if (max_wr && !bf_ff) bd_ff <= max_dist;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         BK_IDLE: begin
            wk_ff <= w_data;
            rem_ff <= {1'b0, w_data.a};
            par_ff <= '0; cnt_ff <= '0; d2_ff <= '0;
         end
         BK_DIV: begin
            if (rsh >= {1'b0, wk_ff.b}) begin
               rem_ff <= rsh - {1'b0, wk_ff.b}; par_ff <= {par_ff[ParamWidth-2:0], 1'b1};
            end else begin
               rem_ff <= rsh; par_ff <= {par_ff[ParamWidth-2:0], 1'b0};
            end
            cnt_ff <= (cnt_ff == 5'd15) ? 5'd0 : cnt_ff + 5'd1;
         end
         BK_FOOT: begin
            diff_ff[ci] <= 34'(35'(qsel) - foot);
            cnt_ff <= (ci == 2'd2) ? 5'd0 : cnt_ff + 5'd1;
         end
         BK_SQ: begin
            d2_ff <= d2_ff + SqWidth'(dsq);
            cnt_ff <= (ci == 2'd2) ? 5'd0 : cnt_ff + 5'd1;
            if (ci == 2'd2) begin
               x_ff <= d2_ff[63:0] + 64'(dsq);
               r_ff <= '0; bit_ff <= 64'h4000_0000_0000_0000;
            end
         end
         BK_SQRT: begin
            if (x_ff >= rb) begin
               x_ff <= x_ff - rb; r_ff <= (r_ff >> 1) + bit_ff;
            end else r_ff <= r_ff >> 1;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
         end
         BK_UPD: dist_ff <= dist_ff;
         default: ;
      endcase
      if (st_ff == BK_SQRT && cnt_ff == 5'd31) begin
         if (d2_ff[SqWidth-1:64] != '0) dist_ff <= 32'hFFFF_FFFF;
         else if (x_ff >= rb) dist_ff <= 32'((r_ff >> 1) + bit_ff);
         else dist_ff <= 32'(r_ff >> 1);
      end
      if (emit_go) begin
         out_f_ff <= bf_ff;
         out_i_ff <= bi_ff; out_p_ff <= bp_ff;
         out_d_ff <= bf_ff ? bd_ff : 32'd0;
      end
   end

   `NSP_ASSERT_NEXT(a_hold_result, clock, reset, out_v_ff && !rsp_pop, out_v_ff, "result dropped while waiting")
   `NSP_ASSERT_NEXT(a_emit_valid, clock, reset, st_ff == BK_EMIT, out_v_ff, "result lost")
   `NSP_ASSERT_IMPL(a_none_zero, clock, reset, out_v_ff && !out_f_ff, out_d_ff == 32'd0 && out_i_ff == '0, "empty result not zero")
endmodule
`default_nettype wire

// ===== rtl/core/nearest_segment_projection_search_top.sv =====
// Path of a qualifying segment: front dot products, hand-over through the queue, divide, foot,
//   square, root, update, emit; a clamped one goes from the hand-over straight to update.
// The back takes a new segment only when idle, and the front takes a new beat only after it has
//   handed the last one to the queue.
// A held result stalls the back only at the next run end; the two-entry queue lets the front work ahead.
// Reset (synchronous, active high): queue and result empty, query zero, bound 1000.0.
`default_nettype none
module nearest_segment_projection_search_top import nsps_pkg::*; #(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic full,
   input  wire logic [31:0] req_start_x, req_start_y, req_start_z,
   input  wire logic [31:0] req_end_x, req_end_y, req_end_z,
   input  wire logic [IndexWidth-1:0] req_segment_index,
   input  wire logic req_last_segment,
   output logic empty,
   input  wire logic pop,
   output logic rsp_found,
   output logic [IndexWidth-1:0] rsp_best_index,
   output logic [ParamWidth-1:0] rsp_best_param,
   output logic [31:0] rsp_best_distance,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   logic [31:0] qx_ff, qy_ff, qz_ff, md_ff;
   logic fv, fr, bv, br, max_wr;
   work_type fd, bd;

   assign csr_ready = 1'b1;
   assign max_wr = csr_valid && (csr_index == RegMaxDist);

   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff <= '0; qy_ff <= '0; qz_ff <= '0; md_ff <= DistReset;
      end else if (csr_valid) begin
         case (csr_index)
            RegQueryX:  qx_ff <= csr_data;
            RegQueryY:  qy_ff <= csr_data;
            RegQueryZ:  qz_ff <= csr_data;
            RegMaxDist: md_ff <= csr_data;
            default: ;
         endcase
      end
   end

   nsps_front u_front (
      .clock, .reset, .in_push(push), .in_full(full),
      .sx(req_start_x), .sy(req_start_y), .sz(req_start_z),
      .ex(req_end_x), .ey(req_end_y), .ez(req_end_z),
      .idx(req_segment_index), .last(req_last_segment),
      .qx(qx_ff), .qy(qy_ff), .qz(qz_ff),
      .w_valid(fv), .w_ready(fr), .w_data(fd)
   );

   nsps_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
      .rd_valid(bv), .rd_ready(br), .rd_data(bd)
   );

   // new bound on a write beat, held bound otherwise
   nsps_back u_back (
      .clock, .reset, .w_valid(bv), .w_ready(br), .w_data(bd),
      .qx(qx_ff), .qy(qy_ff), .qz(qz_ff),
      .max_dist(max_wr ? csr_data : md_ff), .max_wr(max_wr),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_found, .rsp_best_index,
      .rsp_best_param, .rsp_best_distance
   );
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
   import nsps_pkg::*;

   typedef struct {
      logic [31:0] s [3];
      logic [31:0] e [3];
      logic [15:0] idx;
      logic        last;
   } segment_type;

   typedef struct {
      logic        found;
      logic [15:0] index;
      logic [15:0] param;
      logic [31:0] distance;
   } nearest_type;

   class nearest_scoreboard;
      logic [31:0] query [3];
      logic [31:0] bound;
      logic [31:0] run_dist;
      logic [15:0] run_index;
      logic [15:0] run_param;
      logic        run_found;
      nearest_type expected_q [$];
      int          errors;

      function new();
         query = '{default: '0};
         bound = DistReset;
         run_dist = DistReset;
         run_index = '0;
         run_param = '0;
         run_found = 1'b0;
         errors = 0;
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function logic [31:0] root64(logic [63:0] x);
         logic [63:0] r;
         logic [63:0] bit_v;
         r = '0;
         bit_v = 64'd1 << 62;
         while (bit_v > x) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (x >= r + bit_v) begin
               x = x - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return r[31:0];
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] data);
         case (idx)
            RegQueryX: query[0] = data;
            RegQueryY: query[1] = data;
            RegQueryZ: query[2] = data;
            RegMaxDist: begin
               bound = data;
               if (!run_found) run_dist = data;
            end
            default: ;
         endcase
      endfunction

      // project the query onto one segment and fold it into the running best; on the last one, queue the run's result
      function void note_segment(segment_type sg);
         logic signed [33:0]  v1 [3];
         logic signed [33:0]  v2 [3];
         logic signed [79:0]  a, b;
         logic signed [97:0]  num, quot;
         logic signed [63:0]  prod, foot, dif;
         logic [63:0]         m;
         logic [127:0]        d2;
         logic [15:0]         param;
         logic [31:0]         seg_dist;
         nearest_type         res;
         a = '0;
         b = '0;
         d2 = '0;
         for (int i = 0; i < 3; i++) begin
            v1[i] = $signed(sg.e[i]) - $signed(sg.s[i]);
            v2[i] = $signed(query[i]) - $signed(sg.s[i]);
            a = a + v1[i] * v2[i];
            b = b + v1[i] * v1[i];
         end
         if (a > 0 && a < b) begin
            num = a;
            num = num <<< 16;
            quot = num / b;
            param = quot[15:0];
            for (int i = 0; i < 3; i++) begin
               prod = $signed({1'b0, param}) * v1[i];
               foot = $signed(sg.s[i]) + (prod >>> 16);
               dif = $signed(query[i]) - foot;
               m = dif < 0 ? -dif : dif;
               d2 = d2 + m * m;
            end
            seg_dist = d2[127:64] != 0 ? 32'hFFFF_FFFF : root64(d2[63:0]);
            if (seg_dist < run_dist) begin
               run_dist = seg_dist;
               run_index = sg.idx;
               run_param = param;
               run_found = 1'b1;
            end
         end
         if (sg.last) begin
            res.found = run_found;
            res.index = run_found ? run_index : '0;
            res.param = run_found ? run_param : '0;
            res.distance = run_found ? run_dist : '0;
            expected_q.insert(expected_q.size(), res);
            run_found = 1'b0;
            run_index = '0;
            run_param = '0;
            run_dist = bound;
         end
      endfunction

      task check_result(nearest_type got);
         nearest_type exp_r;
         if (expected_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            exp_r = expected_q.pop_front();
            if (got.found !== exp_r.found)
               report_mismatch($sformatf("found %0b, want %0b", got.found, exp_r.found));
            if (got.index !== exp_r.index)
               report_mismatch($sformatf("index %0h, want %0h", got.index, exp_r.index));
            if (got.param !== exp_r.param)
               report_mismatch($sformatf("param %0h, want %0h", got.param, exp_r.param));
            if (got.distance !== exp_r.distance)
               report_mismatch($sformatf("distance %0h, want %0h",
                                         got.distance, exp_r.distance));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic [31:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic [15:0] req_segment_index = '0;
   logic        req_last_segment = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_found;
   logic [15:0] rsp_best_index, rsp_best_param;
   logic [31:0] rsp_best_distance;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   nearest_scoreboard sb = new();
   int tx_idle_pct = 13;
   int rx_idle_pct = 60;
   int rx_hold = 0;
   int cycles = 0;

   localparam int DrainCycles = 400;
   localparam int CycleLimit = 1_000_000;

   nearest_segment_projection_search_top i_dut (
      .clock, .reset, .push, .full,
      .req_start_x, .req_start_y, .req_start_z,
      .req_end_x, .req_end_y, .req_end_z,
      .req_segment_index, .req_last_segment,
      .empty, .pop,
      .rsp_found, .rsp_best_index, .rsp_best_param, .rsp_best_distance,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stalls plus the long hold-off
   initial begin
      nearest_type got;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rx_hold--;
            pop = 1'b0;
         end else begin
            pop = $urandom_range(99) >= rx_idle_pct;
         end
         @(posedge clock);
         if (pop && !empty && !reset) begin
            got.found = rsp_found;
            got.index = rsp_best_index;
            got.param = rsp_best_param;
            got.distance = rsp_best_distance;
            sb.check_result(got);
         end
      end
   end

   function automatic segment_type make_seg(logic [31:0] sx, sy, sz, ex, ey, ez,
                                            logic [15:0] idx, logic last);
      segment_type sg;
      sg.s = '{sx, sy, sz};
      sg.e = '{ex, ey, ez};
      sg.idx = idx;
      sg.last = last;
      return sg;
   endfunction

   task automatic send_segment(segment_type sg);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      {req_start_x, req_start_y, req_start_z} = {sg.s[0], sg.s[1], sg.s[2]};
      {req_end_x, req_end_y, req_end_z} = {sg.e[0], sg.e[1], sg.e[2]};
      req_segment_index = sg.idx;
      req_last_segment = sg.last;
      do @(posedge clock); while (full);
      sb.note_segment(sg);
   endtask

   task automatic stop_push();
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.configure(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for all results, then for segments that make none to clear the pipe
   task automatic settle();
      stop_push();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] near(logic [31:0] centre, int spread);
      return centre + $signed($urandom_range(2 * spread)) - spread;
   endfunction

   function automatic segment_type random_seg();
      segment_type sg;
      int spread;
      spread = 1 << $urandom_range(24, 4);
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(9) == 0) begin
            sg.s[i] = $urandom();
            sg.e[i] = $urandom();
         end else begin
            sg.s[i] = near(sb.query[i], spread);
            sg.e[i] = near(sb.query[i], spread);
         end
      end
      sg.idx = 16'($urandom_range(16'hFFFF));
      sg.last = $urandom_range(5) == 0;
      return sg;
   endfunction

   localparam logic [31:0] One = 32'h0001_0000;
   localparam logic [31:0] MinC = 32'h8000_0000;
   localparam logic [31:0] MaxC = 32'h7FFF_FFFF;

   initial begin
      logic [31:0] q [3];
      logic [31:0] bnd;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, default registers
      send_segment(make_seg(-10 * One, One, 0, 10 * One, One, 0, 16'h0001, 1'b0));
      send_segment(make_seg(-10 * One, One, 0, 10 * One, One, 0, 16'h0002, 1'b0));
      send_segment(make_seg(5 * One, 0, 0, 10 * One, 0, 0, 16'h0003, 1'b0));
      send_segment(make_seg(-10 * One, 0, 0, -5 * One, 0, 0, 16'h0004, 1'b0));
      send_segment(make_seg(One, One, One, One, One, One, 16'h0005, 1'b1));
      send_segment(make_seg(-1, 3, 0, MaxC, 5, 0, 16'hFFFF, 1'b1));
      send_segment(make_seg(MinC, MinC, MinC, MaxC, MaxC, MaxC, 16'h0000, 1'b0));
      send_segment(make_seg(MaxC, MaxC, MinC, MinC, MinC, MaxC, 16'hA5A5, 1'b1));
      send_segment(make_seg(5 * One, 0, 0, 9 * One, 0, 0, 16'h0007, 1'b1));
      settle();

      // bound of zero: no segment can beat it
      write_reg(RegMaxDist, '0);
      send_segment(make_seg(-10 * One, One, 0, 10 * One, One, 0, 16'h0010, 1'b1));
      // bound loaded while a run is open and nothing has qualified yet
      send_segment(make_seg(5 * One, 0, 0, 10 * One, 0, 0, 16'h0011, 1'b0));
      settle();
      write_reg(RegMaxDist, 2 * One);
      send_segment(make_seg(-10 * One, One, 0, 10 * One, One, 0, 16'h0012, 1'b0));
      send_segment(make_seg(-10 * One, 3 * One, 0, 10 * One, 3 * One, 0, 16'h0013, 1'b1));
      settle();

      // far corner: squared distance past 64 bits
      write_reg(RegQueryX, MaxC);
      write_reg(RegQueryY, MaxC);
      write_reg(RegQueryZ, MaxC);
      write_reg(RegMaxDist, 32'hFFFF_FFFF);
      send_segment(make_seg(MinC, MinC, MinC, MinC, MaxC, MinC, 16'h0020, 1'b1));
      send_segment(make_seg(MinC, MinC, MaxC, MaxC, MinC, MinC, 16'h0021, 1'b1));
      settle();

      // long hold-off on the result side so the block backs up
      write_reg(RegQueryX, 0);
      write_reg(RegQueryY, 0);
      write_reg(RegQueryZ, 0);
      write_reg(RegMaxDist, DistReset);
      tx_idle_pct = 0;
      rx_hold = 1500;
      for (int k = 0; k < 12; k++) begin
         send_segment(make_seg(-10 * One, k * One, 0, 10 * One, k * One, One, 16'(k), 1'b1));
      end
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         case (ph / 3)
            0: begin tx_idle_pct = 13; rx_idle_pct = 60; end
            1: begin tx_idle_pct = 60; rx_idle_pct = 13; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int i = 0; i < 3; i++) begin
            case (ph)
               0: q[i] = MinC;
               1: q[i] = MaxC;
               2: q[i] = '0;
               3: q[i] = $urandom();
               default: q[i] = near('0, 1 << 24);
            endcase
         end
         case (ph)
            1: bnd = 32'hFFFF_FFFF;
            4: bnd = '0;
            5: bnd = DistReset;
            default: bnd = $urandom() >> $urandom_range(12);
         endcase
         write_reg(RegQueryX, q[0]);
         write_reg(RegQueryY, q[1]);
         write_reg(RegQueryZ, q[2]);
         write_reg(RegMaxDist, bnd);
         for (int n = 0; n < 120; n++) send_segment(random_seg());
         settle();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
